>>> rtl/evpmq_pkg.sv
// ----------------------------------------------------------------------------
// evpmq_pkg
// Shared types and codes for the event pool match queue: field widths,
// operation and status codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package evpmq_pkg;

    // Fixed field widths
    localparam int CLASS_W    = 16;
    localparam int TYPE_W     = 16;
    localparam int STAMP_W    = 32;
    localparam int DROP_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Operation codes
    localparam logic OP_POST = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOMATCH = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_WC = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_WC  = 4'd1;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_P_LINK = 6'b000010,
        ST_P_APP  = 6'b000100,
        ST_T_CMP  = 6'b001000,
        ST_T_FREE = 6'b010000,
        ST_RESP   = 6'b100000
    } t_state;

endpackage

>>> rtl/evpmq_link_mem.sv
// ----------------------------------------------------------------------------
// evpmq_link_mem
// Slot link memory. One write and one registered read per cycle. A valid
// bit per entry makes an unwritten entry read as its reset link (index+1).
// ----------------------------------------------------------------------------
module evpmq_link_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = 5,
    parameter int SW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [SW-1:0] i_waddr,
    input  logic [IW-1:0] i_wdata,
    input  logic [SW-1:0] i_raddr,
    output logic [IW-1:0] o_rdata
);

    logic [IW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [IW-1:0]    r_q_mem;
    logic             r_q_vld;
    logic [SW-1:0]    r_q_addr;

    // Entry valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q_mem  <= r_mem[i_raddr];
        r_q_vld  <= r_vld[i_raddr];
        r_q_addr <= i_raddr;
    end

    // Unwritten entry: reset link
    assign o_rdata = r_q_vld ? r_q_mem : (IW'(r_q_addr) + IW'(1));

endmodule

>>> rtl/evpmq_slot_mem.sv
// ----------------------------------------------------------------------------
// evpmq_slot_mem
// Slot contents memory: class, type, payload and stamp packed in one word.
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module evpmq_slot_mem #(
    parameter int DEPTH = 16,
    parameter int SW    = 4,
    parameter int DW    = 96
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [SW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [SW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q;

    // Storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> rtl/event_pool_match_queue.sv
// ----------------------------------------------------------------------------
// event_pool_match_queue
// Pool of event slots on a free list and an arrival-ordered pending list.
// Post stores an event, take unlinks the oldest matching one.
// Input channel (i_in_valid / o_in_stall) and output channel
// (o_out_valid / i_out_stall) move one word per request, opcode 0 post,
// 1 take; wildcard writes use the cfg port (i_cfg_valid / o_cfg_ready).
// One request is in flight at a time; o_in_stall is high from acceptance
// until its result has moved into the output register.
// Path to the output register: a drop or a take on an empty list goes
// straight to ST_RESP; a post passes ST_P_LINK and ST_P_APP; a take
// compares in ST_T_CMP, then frees the slot in ST_T_FREE on a match, or
// misses at the list end or after POOL_DEPTH entries. The compare walks
// the list one entry per cycle, the link read being the loop.
// The output register holds a result while i_out_stall is high;
// the next request may be accepted meanwhile but its result waits behind it.
// Reset: synchronous, active low. The free list starts as all slots in
// index order, the pending list empty, counters zero. No clearing pass.
// ----------------------------------------------------------------------------
module event_pool_match_queue
    import evpmq_pkg::*;
#(
    parameter int POOL_DEPTH    = 16,
    parameter int PAYLOAD_WIDTH = 32,
    localparam int IW           = $clog2(POOL_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // requests
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_opcode,
    input  logic [CLASS_W-1:0]       i_event_class,
    input  logic [TYPE_W-1:0]        i_event_type,
    input  logic [PAYLOAD_WIDTH-1:0] i_event_payload,
    input  logic [STAMP_W-1:0]       i_now_ticks,
    // results
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [CLASS_W-1:0]       o_got_class,
    output logic [TYPE_W-1:0]        o_got_type,
    output logic [PAYLOAD_WIDTH-1:0] o_got_payload,
    output logic [STAMP_W-1:0]       o_got_stamp,
    output logic [IW-1:0]            o_slots_in_use,
    output logic [DROP_W-1:0]        o_drop_total
);

    localparam int SW = $clog2(POOL_DEPTH);
    localparam int DW = CLASS_W + TYPE_W + PAYLOAD_WIDTH + STAMP_W;
    localparam logic [IW-1:0] NIL = IW'(POOL_DEPTH);

    // State
    t_state                   r_state, n_state;
    logic [CLASS_W-1:0]       r_class_wc;
    logic [TYPE_W-1:0]        r_type_wc;
    logic [IW-1:0]            r_free_head, n_free_head;
    logic [IW-1:0]            r_pend_head, n_pend_head;
    logic [IW-1:0]            r_pend_tail, n_pend_tail;
    logic [IW-1:0]            r_count, n_count;
    logic [DROP_W-1:0]        r_drop, n_drop;
    logic [IW-1:0]            r_cur, n_cur;
    logic [IW-1:0]            r_prev, n_prev;
    logic [IW-1:0]            r_steps, n_steps;
    logic                     r_any_class, n_any_class;
    logic                     r_any_type, n_any_type;
    logic [CLASS_W-1:0]       r_req_class, n_req_class;
    logic [TYPE_W-1:0]        r_req_type, n_req_type;
    logic [STATUS_W-1:0]      r_res_status, n_res_status;
    logic [CLASS_W-1:0]       r_res_class, n_res_class;
    logic [TYPE_W-1:0]        r_res_type, n_res_type;
    logic [PAYLOAD_WIDTH-1:0] r_res_payload, n_res_payload;
    logic [STAMP_W-1:0]       r_res_stamp, n_res_stamp;

    // Output register
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_out_status;
    logic [CLASS_W-1:0]       r_out_class;
    logic [TYPE_W-1:0]        r_out_type;
    logic [PAYLOAD_WIDTH-1:0] r_out_payload;
    logic [STAMP_W-1:0]       r_out_stamp;
    logic [IW-1:0]            r_out_count;
    logic [DROP_W-1:0]        r_out_drop;

    // Memory ports
    logic                     link_we;
    logic [SW-1:0]            link_waddr;
    logic [IW-1:0]            link_wdata;
    logic [IW-1:0]            link_rdata;
    logic                     slot_we;
    logic [SW-1:0]            rd_addr;
    logic [DW-1:0]            slot_wdata;
    logic [DW-1:0]            slot_rdata;
    logic [CLASS_W-1:0]       slot_class;
    logic [TYPE_W-1:0]        slot_type;
    logic [PAYLOAD_WIDTH-1:0] slot_payload;
    logic [STAMP_W-1:0]       slot_stamp;

    logic                     out_free;
    logic                     out_load;
    logic                     hit;
    logic [IW-1:0]            steps_inc;

    evpmq_link_mem #(
        .DEPTH (POOL_DEPTH),
        .IW    (IW),
        .SW    (SW)
    ) u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    evpmq_slot_mem #(
        .DEPTH (POOL_DEPTH),
        .SW    (SW),
        .DW    (DW)
    ) u_slot (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_free_head[SW-1:0]),
        .i_wdata (slot_wdata),
        .i_raddr (rd_addr),
        .o_rdata (slot_rdata)
    );

    assign slot_wdata = {i_event_class, i_event_type, i_event_payload, i_now_ticks};
    assign {slot_class, slot_type, slot_payload, slot_stamp} = slot_rdata;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = (r_state == ST_RESP) && out_free;

    // Compare unit: one pending entry against the request
    assign hit = (r_any_class || (slot_class == r_req_class)) &&
                 (r_any_type  || (slot_type  == r_req_type));
    assign steps_inc = r_steps + IW'(1);

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_free_head   = r_free_head;
        n_pend_head   = r_pend_head;
        n_pend_tail   = r_pend_tail;
        n_count       = r_count;
        n_drop        = r_drop;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_steps       = r_steps;
        n_any_class   = r_any_class;
        n_any_type    = r_any_type;
        n_req_class   = r_req_class;
        n_req_type    = r_req_type;
        n_res_status  = r_res_status;
        n_res_class   = r_res_class;
        n_res_type    = r_res_type;
        n_res_payload = r_res_payload;
        n_res_stamp   = r_res_stamp;
        link_we       = 1'b0;
        link_waddr    = r_cur[SW-1:0];
        link_wdata    = NIL;
        slot_we       = 1'b0;
        rd_addr       = r_cur[SW-1:0];

        case (r_state)
            ST_IDLE: begin
                // read ahead at the slot the request will need
                rd_addr = (i_opcode == OP_TAKE) ? r_pend_head[SW-1:0] : r_free_head[SW-1:0];
                if (i_in_valid) begin
                    n_req_class   = i_event_class;
                    n_req_type    = i_event_type;
                    n_res_status  = STAT_OK;
                    n_res_class   = '0;
                    n_res_type    = '0;
                    n_res_payload = '0;
                    n_res_stamp   = '0;
                    if (i_opcode == OP_POST) begin
                        if (r_free_head < NIL) begin
                            slot_we = 1'b1;
                            n_cur   = r_free_head;
                            n_state = ST_P_LINK;
                        end else begin
                            // pool full: drop
                            n_res_status = STAT_FULL;
                            if (r_drop != '1) begin
                                n_drop = r_drop + DROP_W'(1);
                            end
                            n_state = ST_RESP;
                        end
                    end else begin
                        n_any_class  = (i_event_class == r_class_wc);
                        n_any_type   = (i_event_type == r_type_wc);
                        n_res_status = STAT_NOMATCH;
                        if (r_pend_head < NIL) begin
                            n_cur   = r_pend_head;
                            n_prev  = NIL;
                            n_steps = '0;
                            n_state = ST_T_CMP;
                        end else begin
                            n_state = ST_RESP;
                        end
                    end
                end
            end
            ST_P_LINK: begin
                // pop free list, new slot ends the chain
                n_free_head = link_rdata;
                link_we     = 1'b1;
                link_waddr  = r_cur[SW-1:0];
                link_wdata  = NIL;
                n_state     = ST_P_APP;
            end
            ST_P_APP: begin
                // append to pending tail
                if (r_pend_tail < NIL) begin
                    link_we    = 1'b1;
                    link_waddr = r_pend_tail[SW-1:0];
                    link_wdata = r_cur;
                end else begin
                    n_pend_head = r_cur;
                end
                n_pend_tail = r_cur;
                n_count     = r_count + IW'(1);
                n_state     = ST_RESP;
            end
            ST_T_CMP: begin
                if (hit) begin
                    // unlink the matching entry
                    if (r_prev < NIL) begin
                        link_we    = 1'b1;
                        link_waddr = r_prev[SW-1:0];
                        link_wdata = link_rdata;
                    end else begin
                        n_pend_head = link_rdata;
                    end
                    if (r_pend_tail == r_cur) begin
                        n_pend_tail = r_prev;
                    end
                    n_res_status  = STAT_OK;
                    n_res_class   = slot_class;
                    n_res_type    = slot_type;
                    n_res_payload = slot_payload;
                    n_res_stamp   = slot_stamp;
                    n_state       = ST_T_FREE;
                end else begin
                    // step along the list, next read issued now
                    n_prev  = r_cur;
                    n_cur   = link_rdata;
                    n_steps = steps_inc;
                    rd_addr = link_rdata[SW-1:0];
                    if (!(link_rdata < NIL) || (steps_inc >= NIL)) begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_T_FREE: begin
                // push slot onto free list
                link_we     = 1'b1;
                link_waddr  = r_cur[SW-1:0];
                link_wdata  = r_free_head;
                n_free_head = r_cur;
                if (r_count != '0) begin
                    n_count = r_count - IW'(1);
                end
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_free_head <= '0;
            r_pend_head <= NIL;
            r_pend_tail <= NIL;
            r_count     <= '0;
            r_drop      <= '0;
            r_cur       <= '0;
            r_prev      <= NIL;
            r_steps     <= '0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_pend_head <= n_pend_head;
            r_pend_tail <= n_pend_tail;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_cur       <= n_cur;
            r_prev      <= n_prev;
            r_steps     <= n_steps;
        end
    end

    // Request and result holding registers
    always_ff @(posedge i_clk) begin
        r_any_class   <= n_any_class;
        r_any_type    <= n_any_type;
        r_req_class   <= n_req_class;
        r_req_type    <= n_req_type;
        r_res_status  <= n_res_status;
        r_res_class   <= n_res_class;
        r_res_type    <= n_res_type;
        r_res_payload <= n_res_payload;
        r_res_stamp   <= n_res_stamp;
    end

    // Wildcard registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_wc <= '0;
            r_type_wc  <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CLASS_WC) begin
                r_class_wc <= i_cfg_data;
            end else if (i_cfg_index == CFG_TYPE_WC) begin
                r_type_wc <= i_cfg_data;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status  <= r_res_status;
            r_out_class   <= r_res_class;
            r_out_type    <= r_res_type;
            r_out_payload <= r_res_payload;
            r_out_stamp   <= r_res_stamp;
            r_out_count   <= r_count;
            r_out_drop    <= r_drop;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_got_class    = r_out_class;
    assign o_got_type     = r_out_type;
    assign o_got_payload  = r_out_payload;
    assign o_got_stamp    = r_out_stamp;
    assign o_slots_in_use = r_out_count;
    assign o_drop_total   = r_out_drop;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("pending count above pool depth");

    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_head < NIL) == (r_pend_tail < NIL))
        else $error("pending head and tail disagree on empty list");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((r_count == '0) == !(r_pend_head < NIL)))
        else $error("pending count disagrees with pending list");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_T_CMP) |-> ((r_steps < NIL) && (r_cur < NIL)))
        else $error("scan past pool depth or on null slot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in flight");

endmodule

>>> test/tb_event_pool_match_queue.sv
// ----------------------------------------------------------------------------
// tb_event_pool_match_queue
// Self-checking bench for the event pool match queue. A list of post and
// take requests is streamed into the block under random idling on both
// sides. Each accepted request is run through a behavioural model of the
// pool: an arrival-ordered list of pending events and a saturating drop
// count. Every result word is then compared field by field with the
// oldest prediction. The wildcard registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_event_pool_match_queue;
    import evpmq_pkg::*;

    localparam int SLOTS    = 16;
    localparam int PAY_W    = 32;
    localparam int USE_W    = $clog2(SLOTS + 1);
    localparam int DROP_MAX = 65535;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'hF;

    typedef struct packed {
        logic               op;
        logic [CLASS_W-1:0] cls;
        logic [TYPE_W-1:0]  typ;
        logic [PAY_W-1:0]   pay;
        logic [STAMP_W-1:0] now;
    } t_ev_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLASS_W-1:0]  cls;
        logic [TYPE_W-1:0]   typ;
        logic [PAY_W-1:0]    pay;
        logic [STAMP_W-1:0]  stamp;
        logic [USE_W-1:0]    in_use;
        logic [DROP_W-1:0]   drops;
    } t_ev_res;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic                  i_opcode        = OP_POST;
    logic [CLASS_W-1:0]    i_event_class   = '0;
    logic [TYPE_W-1:0]     i_event_type    = '0;
    logic [PAY_W-1:0]      i_event_payload = '0;
    logic [STAMP_W-1:0]    i_now_ticks     = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [CLASS_W-1:0]    o_got_class;
    logic [TYPE_W-1:0]     o_got_type;
    logic [PAY_W-1:0]      o_got_payload;
    logic [STAMP_W-1:0]    o_got_stamp;
    logic [USE_W-1:0]      o_slots_in_use;
    logic [DROP_W-1:0]     o_drop_total;

    // Stimulus and scoreboard state
    t_ev_req            req_backlog[$];
    t_ev_res            due_results[$];
    int                 reqs_planned  = 0;
    int                 reqs_accepted = 0;
    int                 mismatches    = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;

    // Model of the pool: pending events oldest first, drop count, wildcards
    t_ev_req            model_events[$];
    logic [DROP_W-1:0]  model_drops = '0;
    logic [CLASS_W-1:0] cls_wc      = '0;
    logic [TYPE_W-1:0]  typ_wc      = '0;

    event_pool_match_queue #(
        .POOL_DEPTH    (SLOTS),
        .PAYLOAD_WIDTH (PAY_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_event_class   (i_event_class),
        .i_event_type    (i_event_type),
        .i_event_payload (i_event_payload),
        .i_now_ticks     (i_now_ticks),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_got_class     (o_got_class),
        .o_got_type      (o_got_type),
        .o_got_payload   (o_got_payload),
        .o_got_stamp     (o_got_stamp),
        .o_slots_in_use  (o_slots_in_use),
        .o_drop_total    (o_drop_total)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run the pool model for one request and return the word it should give
    function automatic t_ev_res serve_request(input t_ev_req r);
        t_ev_res res;
        bit      any_cls;
        bit      any_typ;
        int      hit;
        res = '0;
        hit = -1;
        if (r.op == OP_POST) begin
            if (model_events.size() < SLOTS) begin
                model_events.push_back(r);
                res.status = STAT_OK;
            end else begin
                res.status = STAT_FULL;
                if (model_drops != DROP_W'(DROP_MAX))
                    model_drops++;
            end
        end else begin
            any_cls = (r.cls == cls_wc);
            any_typ = (r.typ == typ_wc);
            // oldest matching entry wins
            for (int k = 0; k < model_events.size() && hit < 0; k++) begin
                if ((any_cls || model_events[k].cls == r.cls) &&
                    (any_typ || model_events[k].typ == r.typ))
                    hit = k;
            end
            if (hit < 0) begin
                res.status = STAT_NOMATCH;
            end else begin
                res.status = STAT_OK;
                res.cls    = model_events[hit].cls;
                res.typ    = model_events[hit].typ;
                res.pay    = model_events[hit].pay;
                res.stamp  = model_events[hit].now;
                model_events.delete(hit);
            end
        end
        res.in_use = USE_W'(model_events.size());
        res.drops  = model_drops;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] seen,
                               input logic [31:0] want);
        if (seen !== want) begin
            if (mismatches < 10)
                $display("mismatch on %s: expected %h, got %h", what, want, seen);
            mismatches++;
        end
    endtask

    // Request driver and receiver stall
    always @(posedge i_clk) begin : drive_req
        t_ev_req nxt;
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = req_backlog.pop_front();
                i_in_valid      <= 1'b1;
                i_opcode        <= nxt.op;
                i_event_class   <= nxt.cls;
                i_event_type    <= nxt.typ;
                i_event_payload <= nxt.pay;
                i_now_ticks     <= nxt.now;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on request words, check result words
    always @(posedge i_clk) begin : watch
        t_ev_res want;
        t_ev_req seen_req;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("result word with no request outstanding");
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", o_status, want.status);
                    check_field("got_class", o_got_class, want.cls);
                    check_field("got_type", o_got_type, want.typ);
                    check_field("got_payload", o_got_payload, want.pay);
                    check_field("got_stamp", o_got_stamp, want.stamp);
                    check_field("slots_in_use", o_slots_in_use, want.in_use);
                    check_field("drop_total", o_drop_total, want.drops);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                seen_req.op  = i_opcode;
                seen_req.cls = i_event_class;
                seen_req.typ = i_event_type;
                seen_req.pay = i_event_payload;
                seen_req.now = i_now_ticks;
                due_results.push_back(serve_request(seen_req));
                reqs_accepted++;
            end
        end
    end

    task automatic plan(input t_ev_req r);
        req_backlog.push_back(r);
        reqs_planned++;
    endtask

    task automatic post_word(input logic [CLASS_W-1:0] cls, input logic [TYPE_W-1:0] typ,
                             input logic [PAY_W-1:0] pay, input logic [STAMP_W-1:0] now);
        t_ev_req r;
        r.op  = OP_POST;
        r.cls = cls;
        r.typ = typ;
        r.pay = pay;
        r.now = now;
        plan(r);
    endtask

    // payload and ticks are don't-care on a take, so fill them randomly
    task automatic take_word(input logic [CLASS_W-1:0] cls, input logic [TYPE_W-1:0] typ);
        t_ev_req r;
        r.op  = OP_TAKE;
        r.cls = cls;
        r.typ = typ;
        r.pay = $urandom;
        r.now = $urandom;
        plan(r);
    endtask

    // Mostly a small alphabet so takes find matches, some wildcards and extremes
    function automatic logic [15:0] pick_code(input logic [15:0] wc);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 16'($urandom_range(1, 3));
        else if (r < 75)
            return wc;
        else if (r < 82)
            return 16'h0000;
        else if (r < 89)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Random traffic; the post share moves in bursts so the pool fills and drains
    task automatic add_random(input int count);
        t_ev_req r;
        int      post_pct;
        post_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                post_pct = 20 + 20 * $urandom_range(0, 3);
            r.op  = ($urandom_range(0, 99) < post_pct) ? OP_POST : OP_TAKE;
            r.cls = pick_code(cls_wc);
            r.typ = pick_code(typ_wc);
            r.pay = $urandom;
            r.now = $urandom;
            plan(r);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (reqs_accepted != reqs_planned || due_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CLASS_WC)
            cls_wc = val;
        else if (idx == CFG_TYPE_WC)
            typ_wc = val;
    endtask

    // Stimulus sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed checks with both wildcards at their reset value of zero
        take_word(16'h0005, 16'h0005);                          // empty list
        post_word(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        post_word(16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        post_word(16'h0001, 16'h0002, 32'hA5A5_A5A5, 32'h0000_0001);
        post_word(16'h0001, 16'h0002, 32'h5A5A_5A5A, 32'h0000_0002);
        post_word(16'h0001, 16'h0003, 32'h1234_5678, 32'h0000_0003);
        take_word(16'h0001, 16'h0002);                          // oldest of two
        take_word(16'h0001, 16'h0000);                          // any type
        take_word(16'h0000, 16'h0003);                          // any class
        take_word(16'h0007, 16'h0007);                          // no match
        for (int k = 0; k < SLOTS - 2; k++)
            post_word(16'(k + 4), 16'(k + 4), $urandom, $urandom);
        post_word(16'h0009, 16'h0009, $urandom, $urandom);       // pool full
        take_word(16'h0000, 16'h0000);                          // both wild: oldest
        add_random(300);
        wait_drained();

        // All-ones wildcards, sender mostly idle
        write_reg(CFG_CLASS_WC, 16'hFFFF);
        write_reg(CFG_TYPE_WC, 16'hFFFF);
        send_idle_pct = 81;
        add_random(300);
        wait_drained();

        // Mid-range wildcards, a write to an unused index, receiver mostly stalled
        write_reg(CFG_CLASS_WC, 16'h0002);
        write_reg(CFG_TYPE_WC, 16'h8001);
        write_reg(CFG_SPARE, 16'($urandom));
        send_idle_pct = 0;
        stall_pct     = 81;
        add_random(300);
        wait_drained();

        // Random class wildcard, light idling both sides
        write_reg(CFG_CLASS_WC, 16'($urandom));
        write_reg(CFG_TYPE_WC, 16'h0000);
        send_idle_pct = 14;
        stall_pct     = 14;
        add_random(300);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog, several times the slowest expected run
    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
